### src/assert_macros.svh
// Assertion macros used by the checker file cma_checker.sv.
// No dependencies; pulled in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define CMA_ASSERT_IMPLY(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CMA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### src/cma_pkg.sv
// Shared constants and inter-module structs for the centered moving average.
// No dependencies.
package cma_pkg;

    localparam int MAX_WINDOW  = 63;
    localparam int SAMPLE_BITS = 16;

    localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
    localparam int SUM_BITS    = SAMPLE_BITS + WIN_BITS;
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_BITS    = $clog2(SUM_BITS + 1);

    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(3);

    // history memory port
    typedef struct packed {
        logic                          we;
        logic [ADDR_BITS-1:0]          waddr;
        logic signed [SAMPLE_BITS-1:0] wdata;
        logic                          re;
        logic [ADDR_BITS-1:0]          raddr;
    } hist_req_t;

    // divider request / response
    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] dividend;
        logic [WIN_BITS-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

### src/cma_history.sv
// Sample history ring: one write port, one registered read port.
// Depends on cma_pkg.
module cma_history (
    input  logic                                    aclk,
    input  cma_pkg::hist_req_t                      req,
    output logic signed [cma_pkg::SAMPLE_BITS-1:0]  rdata
);
    import cma_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/cma_serial_div.sv
// Bit-serial signed divide of the window sum by the window length.
// Restoring, one quotient bit per cycle, truncates toward zero. Depends on cma_pkg.
module cma_serial_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cma_pkg::div_req_t req,
    output cma_pkg::div_rsp_t rsp
);
    import cma_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [SUM_BITS-1:0]     dq_reg;     // dividend bits out, quotient bits in
    logic [WIN_BITS-1:0]     rem_reg;
    logic [WIN_BITS-1:0]     div_reg;
    logic                    neg_reg;

    logic [WIN_BITS:0]       rem_sh;
    logic [WIN_BITS:0]       rem_sub;
    logic                    fits;
    logic [SUM_BITS-1:0]     mag;

    always_comb begin
        rem_sh  = {rem_reg, dq_reg[SUM_BITS-1]};
        fits    = (rem_sh >= {1'b0, div_reg});
        rem_sub = rem_sh - {1'b0, div_reg};
        mag     = req.dividend[SUM_BITS-1] ? SUM_BITS'(-req.dividend)
                                           : SUM_BITS'(req.dividend);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(SUM_BITS);
                dq_reg   <= mag;
                rem_reg  <= '0;
                div_reg  <= req.divisor;
                neg_reg  <= req.dividend[SUM_BITS-1];
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sub[WIN_BITS-1:0] : rem_sh[WIN_BITS-1:0];
                dq_reg  <= {dq_reg[SUM_BITS-2:0], fits};
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? SAMPLE_BITS'(-dq_reg[SAMPLE_BITS-1:0])
                                  : dq_reg[SAMPLE_BITS-1:0];

endmodule

### src/centered_moving_average.sv
// Centered moving average filter, top level.
// Depends on cma_pkg, cma_history and cma_serial_div.
//
// Replaces each signed sample of a stream by the mean of the window of W = 2h+1
// samples centered on it (sum / W, truncated toward zero) once it has h samples
// on either side; samples without a full neighborhood (stream edges, streams
// shorter than W) come out unchanged with m_tuser low. Output lags input by h
// samples: the first h samples of a stream give no result, and the sample
// transferred with s_tlast flushes the trailing ones, the last of them marked by
// m_tlast. W is written through the cfg port (odd values only, even writes are
// dropped; reset W = 3); a write restarts the stream and discards what is
// pending, so write it only while the block is idle. One sample is processed at
// a time: an averaged result goes through the bit-serial divider, which
// retires one quotient bit per cycle, and then to the output register; a
// passed-through result is read from history and loaded to the output, and
// each flushed sample takes a history read and then an output load. The output
// register decouples the result side, so a stalled m_tready only holds the
// block once the next result is ready. History memory is not cleared at reset;
// a stream only ever uses entries it has written.
module centered_moving_average (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input samples
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cma_pkg::TDATA_BITS-1:0]     s_tdata,   // [15:0] sample
    input  logic                               s_tlast,   // last sample of stream
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cma_pkg::TDATA_BITS-1:0]     m_tdata,   // [15:0] value
    output logic                               m_tuser,   // [0] averaged
    output logic                               m_tlast,   // final result of stream
    // window length register
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cma_pkg::WIN_BITS-1:0]       cfg_data   // window_size
);
    import cma_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_EMIT_AVG,
        ST_AFTER,
        ST_LAG_RD,
        ST_EMIT_RAW
    } state_t;

    state_t                        state_reg, state_next;
    logic [WIN_BITS-1:0]           win_reg, win_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [ADDR_BITS-1:0]          wp_reg, wp_next;
    logic [WIN_BITS-1:0]           seen_reg, seen_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          last_reg, last_next;
    logic [WIN_BITS-1:0]           lag_reg, lag_next;
    logic                          flush_reg, flush_next;
    logic                          efinal_reg, efinal_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0]        m_value_reg, m_value_next;
    logic                          m_user_reg, m_user_next;
    logic                          m_last_reg, m_last_next;

    hist_req_t                     hist_req;
    logic signed [SAMPLE_BITS-1:0] hist_rdata;
    div_req_t                      div_req;
    div_rsp_t                      div_rsp;

    logic                          full;
    logic signed [SUM_BITS-1:0]    sum_upd;
    logic [WIN_BITS-1:0]           wp_inc;
    logic [ADDR_BITS-1:0]          wp_adv;
    logic [WIN_BITS-1:0]           seen_upd;
    logic [WIN_BITS-1:0]           half;
    logic [WIN_BITS-1:0]           lag_first;
    logic                          out_free;
    logic signed [SAMPLE_BITS-1:0] s_sample;

    // ring slot of the sample `lag` places back from the newest; wp is the
    // slot the next sample will go to
    function automatic logic [ADDR_BITS-1:0] lag_addr(
        input logic [ADDR_BITS-1:0] wp,
        input logic [WIN_BITS-1:0]  lag,
        input logic [WIN_BITS-1:0]  win
    );
        logic signed [WIN_BITS+1:0] v;
        v = $signed({2'b00, WIN_BITS'(wp)}) - $signed({2'b00, lag})
            - (WIN_BITS+2)'(1);
        if (v < 0) begin
            v = v + $signed({2'b00, win});
        end
        return ADDR_BITS'(v);
    endfunction

    cma_history u_hist (
        .aclk  (aclk),
        .req   (hist_req),
        .rdata (hist_rdata)
    );

    cma_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_sample  = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        // per-sample stream bookkeeping
        half      = win_reg >> 1;
        full      = (seen_reg == win_reg);
        sum_upd   = full ? (sum_reg - SUM_BITS'(hist_rdata)) : sum_reg;
        wp_inc    = WIN_BITS'(wp_reg) + WIN_BITS'(1);
        wp_adv    = (wp_inc >= win_reg) ? '0 : ADDR_BITS'(wp_inc);
        seen_upd  = full ? seen_reg : seen_reg + WIN_BITS'(1);
        // oldest sample still owed at flush
        lag_first = (seen_reg >= half) ? half - WIN_BITS'(1)
                                       : seen_reg - WIN_BITS'(1);
        out_free  = !m_tvalid_reg || m_tready;

        state_next    = state_reg;
        win_next      = win_reg;
        sum_next      = sum_reg;
        wp_next       = wp_reg;
        seen_next     = seen_reg;
        sample_next   = sample_reg;
        last_next     = last_reg;
        lag_next      = lag_reg;
        flush_next    = flush_reg;
        efinal_next   = efinal_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;

        hist_req.we    = 1'b0;
        hist_req.waddr = wp_reg;
        hist_req.wdata = sample_reg;
        hist_req.re    = 1'b0;
        hist_req.raddr = wp_reg;

        div_req.start    = 1'b0;
        div_req.dividend = sum_upd;
        div_req.divisor  = win_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next = s_sample;
                    last_next   = s_tlast;
                    sum_next    = sum_reg + SUM_BITS'(s_sample);
                    hist_req.re = 1'b1;    // fetch the slot about to be overwritten
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                sum_next    = sum_upd;
                hist_req.we = 1'b1;
                wp_next     = wp_adv;
                seen_next   = seen_upd;
                if (seen_upd == win_reg) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end else if (seen_upd > half) begin
                    // center sample passes through; ST_AFTER follows it and flushes after the last sample
                    hist_req.re    = 1'b1;
                    hist_req.raddr = lag_addr(wp_adv, half, win_reg);
                    flush_next     = 1'b0;
                    efinal_next    = 1'b0;
                    state_next     = ST_EMIT_RAW;
                end else begin
                    state_next = ST_AFTER;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_EMIT_AVG;
                end
            end
            ST_EMIT_AVG: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = div_rsp.quotient;
                    m_user_next   = 1'b1;
                    m_last_next   = last_reg && (half == '0);
                    state_next    = ST_AFTER;
                end
            end
            ST_AFTER: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (half == '0) begin
                    sum_next   = '0;
                    wp_next    = '0;
                    seen_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    lag_next   = lag_first;
                    state_next = ST_LAG_RD;
                end
            end
            ST_LAG_RD: begin
                hist_req.re    = 1'b1;
                hist_req.raddr = lag_addr(wp_reg, lag_reg, win_reg);
                flush_next     = 1'b1;
                efinal_next    = (lag_reg == '0);
                state_next     = ST_EMIT_RAW;
            end
            ST_EMIT_RAW: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = hist_rdata;
                    m_user_next   = 1'b0;
                    m_last_next   = efinal_reg;
                    if (!flush_reg) begin
                        state_next = ST_AFTER;
                    end else if (lag_reg == '0) begin
                        sum_next   = '0;
                        wp_next    = '0;
                        seen_next  = '0;
                        flush_next = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        lag_next   = lag_reg - WIN_BITS'(1);
                        state_next = ST_LAG_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // window write: odd values only, restarts the stream
        if (cfg_valid && cfg_data[0]
                && ({1'b0, cfg_data} <= (WIN_BITS+1)'(MAX_WINDOW))) begin
            win_next  = cfg_data;
            sum_next  = '0;
            wp_next   = '0;
            seen_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            win_reg      <= WIN_RESET;
            sum_reg      <= '0;
            wp_reg       <= '0;
            seen_reg     <= '0;
            flush_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            win_reg      <= win_next;
            sum_reg      <= sum_next;
            wp_reg       <= wp_next;
            seen_reg     <= seen_next;
            flush_reg    <= flush_next;
            m_tvalid_reg <= m_tvalid_next;
            sample_reg   <= sample_next;
            last_reg     <= last_next;
            lag_reg      <= lag_next;
            efinal_reg   <= efinal_next;
            m_value_reg  <= m_value_next;
            m_user_reg   <= m_user_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_BITS'(m_value_reg);
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

### src/cma_checker.sv
// Port-level checks for the centered moving average, bound to the top level.
// Depends on cma_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cma_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [cma_pkg::TDATA_BITS-1:0] s_tdata,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cma_pkg::TDATA_BITS-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [cma_pkg::WIN_BITS-1:0]   cfg_data
);
    import cma_pkg::*;

    // stalled result holds its payload
    `CMA_ASSERT_IMPLY(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // one sample at a time: input closes right after a transfer
    `CMA_ASSERT_IMPLY(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input open while a sample is in work")

    // history update comes before any result of a new sample
    `CMA_ASSERT_IMPLY(a_no_early_out, aclk, aresetn, s_tvalid && s_tready |=> !$rose(m_tvalid), "result appeared before history update")

    // out of reset: idle, nothing pending, register port open
    `CMA_ASSERT_IMPLY(a_reset_state, aclk, aresetn, !$past(aresetn) |-> !m_tvalid && s_tready && cfg_ready, "bad state after reset")

endmodule

bind centered_moving_average cma_checker u_cma_checker (.*);
